// ===== rtl/core/fspm_pkg.sv =====
// Shared types and codes of the frame slot pool manager.
package fspm_pkg;

	localparam int FRAME_W = 31;
	localparam int CMP_W   = 9;

	localparam logic [2:0] OP_REGISTER  = 3'd0;
	localparam logic [2:0] OP_DUPLICATE = 3'd1;
	localparam logic [2:0] OP_REMOVE    = 3'd2;
	localparam logic [2:0] OP_FIND_RDY  = 3'd3;
	localparam logic [2:0] OP_FIND_CHG  = 3'd4;
	localparam logic [2:0] OP_SET       = 3'd5;
	localparam logic [2:0] OP_LEVEL     = 3'd6;

	localparam logic [2:0] STS_FREE   = 3'd0;
	localparam logic [2:0] STS_EMPTY  = 3'd1;
	localparam logic [2:0] STS_WAIT   = 3'd2;
	localparam logic [2:0] STS_READY  = 3'd3;
	localparam logic [2:0] STS_LOCKED = 3'd4;

	localparam logic [1:0] RES_OK      = 2'd0;
	localparam logic [1:0] RES_NOMATCH = 2'd1;
	localparam logic [1:0] RES_NOFREE  = 2'd2;

	localparam logic [1:0] QRY_FULL   = 2'd0;
	localparam logic [1:0] QRY_READY  = 2'd1;
	localparam logic [1:0] QRY_EMPTY  = 2'd2;
	localparam logic [1:0] QRY_LOCKED = 2'd3;

	typedef struct packed {
		logic [2:0]         op;
		logic [FRAME_W-1:0] frame_id;
		logic [4:0]         slot;
		logic [2:0]         search_sts;
		logic [2:0]         update_sts;
		logic [1:0]         query_kind;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         result_code;
		logic [4:0]         slot_out;
		logic [FRAME_W-1:0] frame_id_out;
		logic               level_flag;
	} out_item_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_rsp_t;

endpackage

// ===== rtl/core/fspm_stream_if.sv =====
// Valid/ready channel carrying one payload item.
interface fspm_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/fspm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fspm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/fspm_alloc_scan.sv =====
// Round-robin search for a free slot, one slot per cycle.
module fspm_alloc_scan #(
	parameter int NUM_SLOTS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fspm_pkg::CMP_W-1:0]   pool_eff,
	input  logic [$clog2(NUM_SLOTS)-1:0] cursor,
	input  logic [NUM_SLOTS-1:0]         linked,
	output fspm_pkg::scan_rsp_t          rsp,
	output logic [$clog2(NUM_SLOTS)-1:0] idx,
	output logic [$clog2(NUM_SLOTS)-1:0] next_cursor
);
	import fspm_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);

	logic              busy_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     start_q;
	logic [CMP_W-1:0]  cnt_q;
	logic [CMP_W-1:0]  idx_inc;
	logic [IW-1:0]     idx_wrap;
	logic [IW-1:0]     start_idx;

	assign start_idx = (CMP_W'(cursor) < pool_eff) ? cursor : '0;
	assign idx_inc   = CMP_W'(idx_q) + CMP_W'(1);
	assign idx_wrap  = (idx_inc == pool_eff) ? '0 : IW'(idx_inc);

	always_comb begin
		rsp.done    = 1'b0;
		rsp.found   = 1'b0;
		next_cursor = start_q;
		if (busy_q) begin
			if (!linked[idx_q]) begin
				rsp.done    = 1'b1;
				rsp.found   = 1'b1;
				next_cursor = idx_wrap;
			end else if (cnt_q + CMP_W'(1) == pool_eff) begin
				rsp.done = 1'b1;
			end
		end
	end

	assign idx = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			start_q <= '0;
			cnt_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			idx_q   <= start_idx;
			start_q <= start_idx;
			cnt_q   <= '0;
		end else if (busy_q) begin
			if (rsp.done) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_wrap;
				cnt_q <= cnt_q + CMP_W'(1);
			end
		end
	end
endmodule

// ===== rtl/core/frame_slot_pool_manager.sv =====
// Top level of the frame slot pool manager: sequencer around the slot RAM.
//
// Channels: in_ch takes one command item (op, frame_id, slot, search_sts,
// update_sts, query_kind); out_ch gives exactly one result item for each
// command; cfg_ch writes pool_size and is always ready. An item is moved
// when valid and ready are both high at a rising clock edge.
// One command is worked on at a time; in_ch is ready only while the
// sequencer is idle. Per-slot status, frame number and links live in one
// RAM with registered read data, so every list step is a read followed by
// a write. A list walk reads one slot after another from the head, and
// find-and-change follows a match with the status write or removal.
// The free-slot scan visits one slot per cycle, up to the pool size.
// A finished result waits in the output register while out_ch stalls; the
// next command is taken meanwhile, but its result is held back until the
// register is free.
// Reset empties the pool: all slots free, list empty, cursor and counters
// zero, pool_size 32. No clearing pass is needed.
module frame_slot_pool_manager #(
	parameter int NUM_SLOTS = 32
) (
	input logic          clk,
	input logic          arst_n,
	fspm_stream_if.sink   in_ch,
	fspm_stream_if.source out_ch,
	fspm_stream_if.sink   cfg_ch
);
	import fspm_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);
	localparam int LW = $clog2(NUM_SLOTS + 1);
	localparam int EW = 3 + FRAME_W + 2 * LW;
	localparam logic [LW-1:0] NIL = LW'(NUM_SLOTS);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SCAN = 5'd1;
	localparam logic [4:0] S_RG0  = 5'd2;
	localparam logic [4:0] S_RG1  = 5'd3;
	localparam logic [4:0] S_RG2  = 5'd4;
	localparam logic [4:0] S_DP0  = 5'd5;
	localparam logic [4:0] S_DP1  = 5'd6;
	localparam logic [4:0] S_DP2  = 5'd7;
	localparam logic [4:0] S_DP3  = 5'd8;
	localparam logic [4:0] S_DP4  = 5'd9;
	localparam logic [4:0] S_WALK = 5'd10;
	localparam logic [4:0] S_SET  = 5'd11;
	localparam logic [4:0] S_DR0  = 5'd12;
	localparam logic [4:0] S_DR1  = 5'd13;
	localparam logic [4:0] S_DR2  = 5'd14;
	localparam logic [4:0] S_DR3  = 5'd15;
	localparam logic [4:0] S_DR4  = 5'd16;
	localparam logic [4:0] S_OUT  = 5'd17;

	logic [4:0]         state_q;
	in_item_t           item_q;
	in_item_t           in_item;
	logic [5:0]         pool_q;
	logic [NUM_SLOTS-1:0] linked_q;
	logic [LW-1:0]      head_q, tail_q;
	logic [IW-1:0]      cursor_q;
	logic [LW-1:0]      fill_q, ready_q, locked_q;
	logic [IW-1:0]      tgt_q, new_q, cur_q;
	logic [LW-1:0]      steps_q;
	logic [LW-1:0]      pv_q, nx_q;
	logic [FRAME_W-1:0] frame_q;
	logic [2:0]         newst_q;
	out_item_t          res_q, out_q;
	logic               out_valid_q;

	logic               ram_we;
	logic [IW-1:0]      ram_waddr, ram_raddr;
	logic [EW-1:0]      ram_wdata, ram_rdata;
	logic [2:0]         rd_st;
	logic [FRAME_W-1:0] rd_fr;
	logic [LW-1:0]      rd_nx, rd_pv;

	logic [CMP_W-1:0]   pool_eff;
	logic [CMP_W-1:0]   in_slot_ext;
	logic [IW-1:0]      in_idx;
	logic               in_linked;
	logic               accept;
	logic               scan_start;
	scan_rsp_t          scan_rsp;
	logic [IW-1:0]      scan_idx, scan_cursor;
	logic               drop_r, drop_l, add_r, add_l;
	logic               level;

	assign in_item = in_ch.data;
	assign accept  = in_ch.valid && in_ch.ready;
	assign in_ch.ready  = (state_q == S_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	assign rd_st = ram_rdata[EW-1 -: 3];
	assign rd_fr = ram_rdata[EW-4 -: FRAME_W];
	assign rd_nx = ram_rdata[2*LW-1 -: LW];
	assign rd_pv = ram_rdata[LW-1:0];

	// A pool size of zero acts as one; a size beyond the slot count is clipped.
	assign pool_eff = (pool_q == 6'd0) ? CMP_W'(1) :
		((CMP_W'(pool_q) > CMP_W'(NUM_SLOTS)) ? CMP_W'(NUM_SLOTS) : CMP_W'(pool_q));

	assign in_slot_ext = CMP_W'(in_item.slot);
	assign in_idx      = IW'(in_slot_ext);
	assign in_linked   = (in_slot_ext < CMP_W'(NUM_SLOTS)) && linked_q[in_idx];

	assign scan_start = accept && ((in_item.op == OP_REGISTER) ||
		((in_item.op == OP_DUPLICATE) && in_linked));

	assign drop_r = (rd_st == STS_READY) && (ready_q != '0);
	assign drop_l = (rd_st == STS_LOCKED) && (locked_q != '0);
	assign add_r  = (newst_q == STS_READY);
	assign add_l  = (newst_q == STS_LOCKED);

	always_comb begin
		case (in_item.query_kind)
			QRY_FULL:   level = (CMP_W'(fill_q) + CMP_W'(1)) >= pool_eff;
			QRY_READY:  level = (ready_q != '0);
			QRY_EMPTY:  level = (fill_q == '0);
			QRY_LOCKED: level = (locked_q != '0);
			default:    level = 1'b0;
		endcase
	end

	// RAM port control: reads are issued one state ahead of their use.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tgt_q;
		ram_wdata = '0;
		ram_raddr = tgt_q;
		case (state_q)
			S_IDLE: begin
				ram_raddr = ((in_item.op == OP_FIND_RDY) || (in_item.op == OP_FIND_CHG)) ?
					IW'(head_q) : in_idx;
			end
			S_RG0: ram_raddr = IW'(tail_q);
			S_RG1: begin
				ram_we    = 1'b1;
				ram_waddr = IW'(tail_q);
				ram_wdata = {rd_st, rd_fr, LW'(new_q), rd_pv};
			end
			S_RG2: begin
				ram_we    = 1'b1;
				ram_waddr = new_q;
				ram_wdata = {STS_EMPTY, item_q.frame_id, NIL, tail_q};
			end
			S_DP0: ram_raddr = tgt_q;
			S_DP1: begin
				ram_we    = 1'b1;
				ram_waddr = tgt_q;
				ram_wdata = {rd_st, rd_fr, LW'(new_q), rd_pv};
			end
			S_DP2: ram_raddr = IW'(nx_q);
			S_DP3: begin
				ram_we    = 1'b1;
				ram_waddr = IW'(nx_q);
				ram_wdata = {rd_st, rd_fr, rd_nx, LW'(new_q)};
			end
			S_DP4: begin
				ram_we    = 1'b1;
				ram_waddr = new_q;
				ram_wdata = {STS_WAIT, frame_q, nx_q, LW'(tgt_q)};
			end
			S_WALK: begin
				// A match re-reads the slot for the status update; otherwise follow the link.
				if ((item_q.op == OP_FIND_CHG) && (rd_st == item_q.search_sts)) begin
					ram_raddr = cur_q;
				end else begin
					ram_raddr = IW'(rd_nx);
				end
			end
			S_SET: begin
				ram_we    = (newst_q != STS_FREE);
				ram_waddr = tgt_q;
				ram_wdata = {newst_q, rd_fr, rd_nx, rd_pv};
			end
			S_DR0: ram_raddr = IW'(pv_q);
			S_DR1: begin
				ram_we    = 1'b1;
				ram_waddr = IW'(pv_q);
				ram_wdata = {rd_st, rd_fr, nx_q, rd_pv};
			end
			S_DR2: ram_raddr = IW'(nx_q);
			S_DR3: begin
				ram_we    = 1'b1;
				ram_waddr = IW'(nx_q);
				ram_wdata = {rd_st, rd_fr, rd_nx, pv_q};
			end
			default: ;
		endcase
	end

	fspm_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fspm_alloc_scan #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_alloc_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (scan_start),
		.pool_eff    (pool_eff),
		.cursor      (cursor_q),
		.linked      (linked_q),
		.rsp         (scan_rsp),
		.idx         (scan_idx),
		.next_cursor (scan_cursor)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= 6'd32;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			pool_q <= cfg_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && (!out_valid_q || out_ch.ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && (!out_valid_q || out_ch.ready)) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			linked_q <= '0;
			head_q   <= NIL;
			tail_q   <= NIL;
			cursor_q <= '0;
			fill_q   <= '0;
			ready_q  <= '0;
			locked_q <= '0;
			item_q   <= '0;
			res_q    <= '0;
			tgt_q    <= '0;
			new_q    <= '0;
			cur_q    <= '0;
			steps_q  <= '0;
			pv_q     <= '0;
			nx_q     <= '0;
			frame_q  <= '0;
			newst_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q <= in_item;
						res_q  <= '{
							result_code: (in_item.op == OP_LEVEL) ? RES_OK : RES_NOMATCH,
							slot_out: '0, frame_id_out: '0,
							level_flag: (in_item.op == OP_LEVEL) && level};
						tgt_q   <= in_idx;
						newst_q <= (in_item.op == OP_REMOVE) ? STS_FREE : in_item.update_sts;
						cur_q   <= IW'(head_q);
						steps_q <= '0;
						case (in_item.op)
							OP_REGISTER:  state_q <= S_SCAN;
							OP_DUPLICATE: state_q <= in_linked ? S_SCAN : S_OUT;
							OP_REMOVE, OP_SET: state_q <= in_linked ? S_SET : S_OUT;
							OP_FIND_RDY, OP_FIND_CHG: begin
								state_q <= (head_q != NIL) ? S_WALK : S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_rsp.done) begin
						cursor_q <= scan_cursor;
						new_q    <= scan_idx;
						if (!scan_rsp.found) begin
							res_q.result_code <= RES_NOFREE;
							state_q <= S_OUT;
						end else if (item_q.op == OP_REGISTER) begin
							state_q <= S_RG0;
						end else begin
							state_q <= S_DP0;
						end
					end
				end
				S_RG0: state_q <= (tail_q != NIL) ? S_RG1 : S_RG2;
				S_RG1: state_q <= S_RG2;
				S_RG2: begin
					linked_q[new_q] <= 1'b1;
					if (tail_q == NIL) head_q <= LW'(new_q);
					tail_q <= LW'(new_q);
					fill_q <= fill_q + LW'(1);
					res_q  <= '{result_code: RES_OK, slot_out: 5'(new_q),
						frame_id_out: item_q.frame_id, level_flag: 1'b0};
					state_q <= S_OUT;
				end
				S_DP0: state_q <= S_DP1;
				S_DP1: begin
					frame_q <= rd_fr;
					nx_q    <= rd_nx;
					state_q <= S_DP2;
				end
				S_DP2: state_q <= (nx_q != NIL) ? S_DP3 : S_DP4;
				S_DP3: state_q <= S_DP4;
				S_DP4: begin
					linked_q[new_q] <= 1'b1;
					if (nx_q == NIL) tail_q <= LW'(new_q);
					fill_q <= fill_q + LW'(1);
					res_q  <= '{result_code: RES_OK, slot_out: 5'(new_q),
						frame_id_out: frame_q, level_flag: 1'b0};
					state_q <= S_OUT;
				end
				S_WALK: begin
					if (item_q.op == OP_FIND_RDY && rd_st == STS_LOCKED) begin
						state_q <= S_OUT;
					end else if (item_q.op == OP_FIND_RDY && rd_st == STS_READY) begin
						res_q.result_code  <= RES_OK;
						res_q.slot_out     <= 5'(cur_q);
						res_q.frame_id_out <= rd_fr;
						state_q <= S_OUT;
					end else if (item_q.op == OP_FIND_CHG && rd_st == item_q.search_sts) begin
						tgt_q   <= cur_q;
						state_q <= S_SET;
					end else if ((rd_nx == NIL) || (steps_q + LW'(1) == NIL)) begin
						state_q <= S_OUT;
					end else begin
						cur_q   <= IW'(rd_nx);
						steps_q <= steps_q + LW'(1);
					end
				end
				S_SET: begin
					pv_q <= rd_pv;
					nx_q <= rd_nx;
					res_q.result_code  <= RES_OK;
					res_q.slot_out     <= 5'(tgt_q);
					res_q.frame_id_out <= rd_fr;
					if (newst_q == STS_FREE) begin
						ready_q  <= ready_q - LW'(drop_r);
						locked_q <= locked_q - LW'(drop_l);
						state_q  <= S_DR0;
					end else begin
						ready_q  <= ready_q - LW'(drop_r) + LW'(add_r);
						locked_q <= locked_q - LW'(drop_l) + LW'(add_l);
						state_q  <= S_OUT;
					end
				end
				S_DR0: state_q <= (pv_q != NIL) ? S_DR1 : S_DR2;
				S_DR1: state_q <= S_DR2;
				S_DR2: state_q <= (nx_q != NIL) ? S_DR3 : S_DR4;
				S_DR3: state_q <= S_DR4;
				S_DR4: begin
					linked_q[tgt_q] <= 1'b0;
					if (tail_q == LW'(tgt_q)) tail_q <= pv_q;
					if (head_q == LW'(tgt_q)) head_q <= nx_q;
					if (fill_q != '0) fill_q <= fill_q - LW'(1);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ch.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The fill count tracks the number of linked slots exactly.
	a_fill_matches_linked: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(linked_q) == int'(fill_q))
		else $error("fill count differs from number of linked slots");

	// The list is either empty at both ends or at neither.
	a_head_tail_nil: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NIL) == (tail_q == NIL))
		else $error("head and tail disagree on an empty list");

	// A newly registered slot must have been free when the scan picked it.
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RG2 || state_q == S_DP4) |-> !linked_q[new_q])
		else $error("allocated slot already linked");

	// A taken command always moves the sequencer out of idle.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("sequencer stayed idle after taking an item");
endmodule
